FILE: src/stps_pkg.sv
// Shared types, stream field layout and the sequencer control store
// for the sorted table predecessor search unit. No dependencies.
`default_nettype none

package stps_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int DEFAULT_VALUE_WIDTH = 64;

  localparam int FIELD_WIDTH   = 64;
  localparam int POS_WIDTH     = 8;
  localparam int IN_DATA_W     = 2 * FIELD_WIDTH;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = POS_WIDTH;
  localparam int OUT_USER_W    = 2;

  localparam int IN_USER_MODE  = 0;
  localparam int IN_USER_START = 1;
  localparam int OUT_USER_NONE = 0;
  localparam int OUT_USER_OVF  = 1;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_APPEND = 3'd1;
  localparam step_t STEP_QINIT  = 3'd2;
  localparam step_t STEP_PROBE  = 3'd3;
  localparam step_t STEP_QDONE  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_QINIT,
    OP_PROBE,
    OP_QDONE
  } op_t;

  typedef enum logic [1:0] {
    COND_ACCEPT,
    COND_EMIT,
    COND_SEARCH
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    unique case (step)
      STEP_WAIT:   uc = '{in_ready: 1'b1, op: OP_NONE,   cond: COND_ACCEPT, target: STEP_WAIT};
      STEP_APPEND: uc = '{in_ready: 1'b0, op: OP_APPEND, cond: COND_EMIT,   target: STEP_WAIT};
      STEP_QINIT:  uc = '{in_ready: 1'b0, op: OP_QINIT,  cond: COND_SEARCH, target: STEP_QDONE};
      STEP_PROBE:  uc = '{in_ready: 1'b0, op: OP_PROBE,  cond: COND_SEARCH, target: STEP_QDONE};
      STEP_QDONE:  uc = '{in_ready: 1'b0, op: OP_QDONE,  cond: COND_EMIT,   target: STEP_WAIT};
      default:     uc = '{in_ready: 1'b0, op: OP_NONE,   cond: COND_EMIT,   target: STEP_WAIT};
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

FILE: src/stps_ram.sv
// Generic simple dual port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module stps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/sorted_table_predecessor_search_unit.sv
// Top level of the sorted table predecessor search unit: a microcoded
// sequencer over a table RAM. Depends on stps_pkg and stps_ram.
`default_nettype none

// Each input word either appends a value to an ascending table or searches
// the table for the last entry not greater than a key; every input word gives
// exactly one result word. An append is registered in its append step once
// the output is free, as is a query's result in its done step. A query runs
// an init step, then one binary search probe per step, at most
// ceil(log2(TABLE_DEPTH + 1)) probes; the single table read port serves one
// probe per cycle. A new word is accepted in the cycle after the previous
// word's result is registered, so none is taken while a word is in work.
// The result register holds a word while the output is stalled.

module sorted_table_predecessor_search_unit #(
  parameter int TABLE_DEPTH = stps_pkg::DEFAULT_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stps_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: entry_value[63:0], query_key[127:64].
  input  wire logic [stps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: mode[0], start_new[1].
  input  wire logic [stps_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: position[7:0].
  output logic      [stps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: none_found[0], overflow[1].
  output logic      [stps_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  import stps_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  step_t  step, step_next;
  ucode_t uc;

  logic [CW-1:0]          count, count_next;
  logic                   ovf_flag, ovf_flag_next;
  logic [CW-1:0]          lo, lo_next, hi, hi_next;
  logic [VALUE_WIDTH-1:0] key, entry;
  logic                   start_new;

  logic [POS_WIDTH-1:0]   pos_r, pos_next;
  logic                   none_r, none_next, ovf_r, ovf_next;
  logic                   m_valid_next;

  logic                   in_acc, out_free, more, emit;
  logic [CW-1:0]          count_eff;
  logic                   full;
  logic [CW:0]            mid_sum;
  logic [AW-1:0]          mid_next;
  logic                   ram_we, ram_re;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Probe address of the read whose data is compared in the current step.
  logic [AW-1:0] lo_mid;

  assign uc       = ucode_rom(step);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit     = (uc.cond == COND_EMIT) && out_free;

  assign s_axis_tready = uc.in_ready;
  assign m_axis_tdata  = pos_r;
  assign m_axis_tuser  = {ovf_r, none_r};

  assign count_eff = start_new ? '0 : count;
  assign full      = (count_eff == CW'(TABLE_DEPTH));
  assign mid_sum   = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next  = mid_sum[AW:1];
  assign more      = lo_next < hi_next;
  assign ram_we    = (uc.op == OP_APPEND) && emit && !full;
  assign ram_re    = (uc.op == OP_QINIT) || (uc.op == OP_PROBE);

  stps_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_eff[AW-1:0]),
    .wdata (entry),
    .re    (ram_re),
    .raddr (mid_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    lo_next       = lo;
    hi_next       = hi;
    count_next    = count;
    ovf_flag_next = ovf_flag;
    pos_next      = pos_r;
    none_next     = none_r;
    ovf_next      = ovf_r;
    unique case (uc.op)
      OP_NONE: begin
      end
      OP_APPEND: begin
        if (emit) begin
          count_next    = full ? count_eff : count_eff + CW'(1);
          ovf_flag_next = (start_new ? 1'b0 : ovf_flag) | full;
          pos_next      = full ? '0 : POS_WIDTH'(count_eff);
          none_next     = 1'b0;
          ovf_next      = full;
        end
      end
      OP_QINIT: begin
        lo_next = '0;
        hi_next = count;
      end
      OP_PROBE: begin
        lo_next = (ram_rdata <= key) ? CW'(lo_mid) + CW'(1) : lo;
        hi_next = (ram_rdata <= key) ? hi : CW'(lo_mid);
      end
      OP_QDONE: begin
        if (emit) begin
          pos_next  = (lo == '0) ? '0 : POS_WIDTH'(lo - CW'(1));
          none_next = (lo == '0);
          ovf_next  = ovf_flag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      lo_mid <= mid_next;
    end
  end

  always_comb begin
    unique case (uc.cond)
      COND_ACCEPT: begin
        if (in_acc) begin
          step_next = (s_axis_tuser[IN_USER_MODE] == MODE_QUERY) ? STEP_QINIT : STEP_APPEND;
        end else begin
          step_next = step;
        end
      end
      COND_EMIT:   step_next = out_free ? uc.target : step;
      COND_SEARCH: step_next = more ? STEP_PROBE : uc.target;
      default:     step_next = STEP_WAIT;
    endcase
  end

  always_comb begin
    m_valid_next = m_axis_tvalid && !m_axis_tready;
    if (emit) begin
      m_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_WAIT;
      count         <= '0;
      ovf_flag      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      step          <= step_next;
      count         <= count_next;
      ovf_flag      <= ovf_flag_next;
      m_axis_tvalid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    pos_r  <= pos_next;
    none_r <= none_next;
    ovf_r  <= ovf_next;
    if (in_acc) begin
      entry     <= s_axis_tdata[VALUE_WIDTH-1:0];
      key       <= s_axis_tdata[FIELD_WIDTH +: VALUE_WIDTH];
      start_new <= s_axis_tuser[IN_USER_START];
    end
  end

endmodule

`default_nettype wire

FILE: src/stps_checker.sv
// Port-level checker for the sorted table predecessor search unit and the
// bind that attaches it. Depends on stps_pkg.
`default_nettype none

module stps_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [stps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [stps_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [stps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [stps_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  import stps_pkg::*;

  logic unused_in;

  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word visible right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while the first is still in work");

  a_none_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[OUT_USER_NONE] |-> m_axis_tdata == '0)
    else $error("position not zero on a word without predecessor");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
      && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed or dropped");

endmodule

bind sorted_table_predecessor_search_unit stps_checker u_stps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: sim/sorted_table_predecessor_search_unit_test.sv
// Self-checking testbench for the sorted table predecessor search unit: appends
// and key searches are streamed in and every result word is checked against an
// in-bench model of the table. Depends on stps_pkg and the unit's RTL.
module sorted_table_predecessor_search_unit_test;
  import stps_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int RANDOM_ITEMS = 1100;
  localparam int LIMIT_CYCLES = 400000;
  localparam int END_WAIT     = 40;

  typedef struct packed {
    logic        mode;
    logic        start_new;
    logic [63:0] value;
    logic [63:0] key;
  } search_item_t;

  typedef struct packed {
    logic [7:0] position;
    logic       none_found;
    logic       overflow;
  } search_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  search_item_t   pending_items[$];
  search_result_t expected_results[$];
  search_item_t   cur_item;
  search_item_t   nxt_item;
  search_result_t got_result;

  logic [63:0] table_mem[TABLE_DEPTH];
  int fill = 0;
  logic dropped = 1'b0;

  int total_items = 0;
  int directed_n = 0;
  int issued = 0;
  int sent_count = 0;
  int got_count = 0;
  int phase = 0;
  int next_phase;
  int sent_now;
  int errors = 0;
  int cycles = 0;
  logic took;
  logic may_go;

  int n_append = 0;
  int n_query = 0;
  int n_none = 0;
  int n_drop = 0;
  int peak_fill = 0;

  sorted_table_predecessor_search_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 40)
      $display("mismatch at result %0d: %s", got_count, msg);
    errors++;
  endtask

  task automatic add_item(input logic mode, input logic start_new, input logic [63:0] value,
                          input logic [63:0] key);
    search_item_t it;
    it.mode = mode;
    it.start_new = start_new;
    it.value = value;
    it.key = key;
    pending_items.push_back(it);
  endtask

  // Updates the table model and returns the result word the item must produce.
  function automatic search_result_t predict_result(input search_item_t it);
    search_result_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    if (it.mode == MODE_APPEND) begin
      n_append++;
      if (it.start_new) begin
        fill = 0;
        dropped = 1'b0;
      end
      if (fill >= TABLE_DEPTH) begin
        dropped = 1'b1;
        r.overflow = 1'b1;
        n_drop++;
      end else begin
        table_mem[fill] = it.value;
        r.position = 8'(fill);
        fill++;
        if (fill > peak_fill) peak_fill = fill;
      end
    end else begin
      n_query++;
      lo = 0;
      hi = fill;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (table_mem[mid] <= it.key) lo = mid + 1;
        else hi = mid;
      end
      if (lo == 0) begin
        r.none_found = 1'b1;
        n_none++;
      end else begin
        r.position = 8'(lo - 1);
      end
      r.overflow = dropped;
    end
    return r;
  endfunction

  task automatic add_query(input logic [63:0] near);
    logic [63:0] k;
    k = near;
    case ($urandom_range(7))
      0, 1: k = near;
      2: k = near - 64'd1;
      3: k = near + 64'd1;
      4: k = '0;
      5: k = '1;
      default: k = rand64() >> $urandom_range(0, 63);
    endcase
    add_item(MODE_QUERY, $urandom_range(9) == 0, rand64(), k);
  endtask

  task automatic build_random_part();
    logic [63:0] run_vals[$];
    logic [63:0] v;
    logic [63:0] prev;
    logic [63:0] step;
    int len;
    int n;
    int q;
    logic first;
    logic continue_run;
    first = 1'b1;
    while (pending_items.size() - directed_n < RANDOM_ITEMS) begin
      if (first) len = TABLE_DEPTH + 6;
      else if ($urandom_range(11) == 0) len = $urandom_range(40, TABLE_DEPTH + 6);
      else len = $urandom_range(1, 16);
      continue_run = !first && ($urandom_range(19) == 0);
      if (!continue_run) run_vals.delete();
      prev = rand64() >> $urandom_range(0, 63);
      if ($urandom_range(7) == 0) prev = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 400);
      for (n = 0; n < len; n++) begin
        if ($urandom_range(14) == 0) begin
          v = rand64();
        end else begin
          if ($urandom_range(2) == 0) step = rand64() >> $urandom_range(8, 63);
          else step = 64'($urandom_range(0, 2));
          v = prev + step;
          if (v < prev) v = '1;
        end
        prev = v;
        add_item(MODE_APPEND, (n == 0) && !continue_run, v, rand64());
        run_vals.push_back(v);
        q = ($urandom_range(1) == 0) ? $urandom_range(1, 2) : 0;
        repeat (q) add_query(run_vals[$urandom_range(run_vals.size() - 1)]);
      end
      first = 1'b0;
    end
  endtask

  initial begin
    // Searches on the empty table after reset.
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd0);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(MODE_APPEND, 1'b1, 64'd100, rand64());
    add_item(MODE_APPEND, 1'b0, 64'd200, rand64());
    add_item(MODE_APPEND, 1'b0, 64'd300, rand64());
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd99);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd100);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd250);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd300);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'hFFFF_FFFF_FFFF_FFFF);
    // The start flag on a search must leave the table alone.
    add_item(MODE_QUERY, 1'b1, rand64(), 64'd150);
    add_item(MODE_APPEND, 1'b1, 64'd0, rand64());
    add_item(MODE_APPEND, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, rand64());
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd0);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'hFFFF_FFFF_FFFF_FFFE);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'hFFFF_FFFF_FFFF_FFFF);
    // An unsorted table still runs the same probe sequence as the bench model.
    add_item(MODE_APPEND, 1'b1, 64'd500, rand64());
    add_item(MODE_APPEND, 1'b0, 64'd10, rand64());
    add_item(MODE_APPEND, 1'b0, 64'd700, rand64());
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd600);
    add_item(MODE_QUERY, 1'b0, rand64(), 64'd5);
    add_item(MODE_APPEND, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    add_item(MODE_QUERY, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    directed_n = pending_items.size();
    build_random_part();
    total_items = pending_items.size();

    @(posedge clk);
    while (rst || sent_count != total_items || got_count != total_items) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d appends (%0d dropped, table up to %0d entries) and %0d searches",
             n_append, n_drop, peak_fill, n_query);
    $display("%0d searches found no predecessor; idle and stall phases all exercised", n_none);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Input side: presents one pending word at a time and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        expected_results.push_back(predict_result(cur_item));
        sent_count <= sent_count + 1;
      end
      sent_now = sent_count + int'(took);
      if (!s_axis_tvalid || took) begin
        may_go = pending_items.size() != 0;
        if (may_go) begin
          next_phase = issued * 4 / total_items;
          // Drain the unit completely before the random part and each new phase.
          if ((next_phase != phase || issued == directed_n) && got_count != sent_now)
            may_go = 1'b0;
          else if (next_phase == 1 && $urandom_range(99) < 47)
            may_go = 1'b0;
          else if (next_phase == 3 && $urandom_range(99) < 36)
            may_go = 1'b0;
        end
        if (may_go) begin
          nxt_item = pending_items.pop_front();
          cur_item = nxt_item;
          issued++;
          phase <= next_phase;
          s_axis_tdata <= {nxt_item.key, nxt_item.value};
          s_axis_tuser <= {nxt_item.start_new, nxt_item.mode};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: stalls by phase and checks each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          got_result = expected_results.pop_front();
          if (m_axis_tdata !== got_result.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      m_axis_tdata, got_result.position));
          if (m_axis_tuser[OUT_USER_NONE] !== got_result.none_found)
            report_mismatch($sformatf("none_found %b, expected %b",
                                      m_axis_tuser[OUT_USER_NONE], got_result.none_found));
          if (m_axis_tuser[OUT_USER_OVF] !== got_result.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      m_axis_tuser[OUT_USER_OVF], got_result.overflow));
        end
        got_count <= got_count + 1;
      end
      if (phase == 2)
        m_axis_tready <= $urandom_range(99) >= 47;
      else if (phase == 3)
        m_axis_tready <= $urandom_range(99) >= 36;
      else
        m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

endmodule
